// File: rtl/core/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// shared constants and controller/datapath command and status types
// ----------------------------------------------------------------------------
package sha1_pkg;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [5:0] LENGTH_POS = 6'd56;
   localparam logic [5:0] LAST_POS   = 6'd63;
   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [2:0] LAST_WORD  = 3'd4;

   // byte source codes
   localparam logic [1:0] SRC_DATA = 2'd0;
   localparam logic [1:0] SRC_PAD  = 2'd1;
   localparam logic [1:0] SRC_ZERO = 2'd2;
   localparam logic [1:0] SRC_LEN  = 2'd3;

   // round function codes
   localparam logic [1:0] FN_CH     = 2'd0;
   localparam logic [1:0] FN_PARITY = 2'd1;
   localparam logic [1:0] FN_MAJ    = 2'd2;
   localparam logic [1:0] FN_PAR2   = 2'd3;

   typedef struct packed {
      logic       put_byte;
      logic [1:0] byte_src;
      logic       count_bits;
      logic       load_work;
      logic       round_en;
      logic [1:0] round_fn;
      logic       add_chain;
      logic       reload;
      logic [2:0] out_sel;
   } cmd_type;

   typedef struct packed {
      logic pos_last;
      logic pos_length;
   } status_type;

endpackage

// File: rtl/core/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// sha1_ctrl
// sequencer for byte intake, padding, the 80 rounds and digest readout
// ----------------------------------------------------------------------------
module sha1_ctrl import sha1_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_byte_valid,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_word_index,
   output logic       rsp_last_word,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_ROUND = 3'd2;
   localparam logic [2:0] S_FINAL = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;
   logic       pad80_ff, pad80_in;
   logic       len_phase_ff, len_phase_in;
   logic       resume_pad_ff, resume_pad_in;
   logic       final_blk_ff, final_blk_in;
   logic       req_fire;

   assign req_fire       = req_valid && req_ready;
   assign rsp_word_index = word_ff;
   assign rsp_last_word  = (word_ff == LAST_WORD);

   always_comb begin
      state_in      = state_ff;
      round_in      = round_ff;
      word_in       = word_ff;
      pad80_in      = pad80_ff;
      len_phase_in  = len_phase_ff;
      resume_pad_in = resume_pad_ff;
      final_blk_in  = final_blk_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd           = '0;
      cmd.out_sel   = word_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.put_byte   = req_byte_valid;
               cmd.byte_src   = SRC_DATA;
               cmd.count_bits = req_byte_valid;
               pad80_in       = 1'b0;
               len_phase_in   = 1'b0;
               final_blk_in   = 1'b0;
               if (req_byte_valid && status.pos_last) begin
                  cmd.load_work = 1'b1;
                  round_in      = '0;
                  resume_pad_in = req_last;
                  state_in      = S_ROUND;
               end else if (req_last) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            cmd.put_byte = 1'b1;
            if (!pad80_ff) begin
               cmd.byte_src = SRC_PAD;
            end else if (len_phase_ff || status.pos_length) begin
               cmd.byte_src = SRC_LEN;
            end else begin
               cmd.byte_src = SRC_ZERO;
            end
            pad80_in = 1'b1;
            if (pad80_ff && status.pos_length) begin
               len_phase_in = 1'b1;
            end
            if (status.pos_last) begin
               cmd.load_work = 1'b1;
               round_in      = '0;
               resume_pad_in = 1'b1;
               final_blk_in  = (cmd.byte_src == SRC_LEN);
               state_in      = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            if (round_ff < 7'd20) begin
               cmd.round_fn = FN_CH;
            end else if (round_ff < 7'd40) begin
               cmd.round_fn = FN_PARITY;
            end else if (round_ff < 7'd60) begin
               cmd.round_fn = FN_MAJ;
            end else begin
               cmd.round_fn = FN_PAR2;
            end
            if (round_ff == LAST_ROUND) begin
               round_in = '0;
               state_in = S_FINAL;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         S_FINAL: begin
            cmd.add_chain = 1'b1;
            if (final_blk_ff) begin
               word_in  = '0;
               state_in = S_OUT;
            end else if (resume_pad_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (word_ff == LAST_WORD) begin
                  cmd.reload   = 1'b1;
                  word_in      = '0;
                  final_blk_in = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         round_ff      <= '0;
         word_ff       <= '0;
         pad80_ff      <= 1'b0;
         len_phase_ff  <= 1'b0;
         resume_pad_ff <= 1'b0;
         final_blk_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         round_ff      <= round_in;
         word_ff       <= word_in;
         pad80_ff      <= pad80_in;
         len_phase_ff  <= len_phase_in;
         resume_pad_ff <= resume_pad_in;
         final_blk_ff  <= final_blk_in;
      end
   end

endmodule

// File: rtl/core/sha1_datapath.sv
// ----------------------------------------------------------------------------
// sha1_datapath
// block shift line with rolling schedule, round unit, chaining state, counters
// ----------------------------------------------------------------------------
module sha1_datapath import sha1_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  data_byte,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [31:0] digest_word
);

   logic [511:0] blk_ff, blk_in;
   logic [31:0]  chain_ff [5];
   logic [31:0]  chain_in [5];
   logic [31:0]  work_ff [5];
   logic [31:0]  work_in [5];
   logic [63:0]  bitlen_ff, bitlen_in;
   logic [5:0]   pos_ff, pos_in;
   logic [7:0]   byte_val;
   logic [2:0]   len_sel;
   logic [31:0]  w_cur, w_new, f_val, k_val, t_val;

   function automatic logic [31:0] rol(input logic [31:0] v, input int s);
      rol = (v << s) | (v >> (32 - s));
   endfunction

   assign status.pos_last   = (pos_ff == LAST_POS);
   assign status.pos_length = (pos_ff == LENGTH_POS);

   assign len_sel = ~pos_ff[2:0];

   always_comb begin
      case (cmd.byte_src)
         SRC_DATA: byte_val = data_byte;
         SRC_PAD:  byte_val = PAD_BYTE;
         SRC_ZERO: byte_val = 8'h00;
         SRC_LEN:  byte_val = bitlen_ff[{len_sel, 3'b000} +: 8];
         default:  byte_val = 8'h00;
      endcase
   end

   // schedule taps: word i of the line is w[t+i]
   assign w_cur = blk_ff[511:480];
   assign w_new = rol(blk_ff[95:64] ^ blk_ff[255:224] ^ blk_ff[447:416] ^ blk_ff[511:480], 1);

   always_comb begin
      case (cmd.round_fn)
         FN_CH: begin
            f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
            k_val = K0;
         end
         FN_PARITY: begin
            f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
            k_val = K1;
         end
         FN_MAJ: begin
            f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3])
                  | (work_ff[2] & work_ff[3]);
            k_val = K2;
         end
         FN_PAR2: begin
            f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
            k_val = K3;
         end
         default: begin
            f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
            k_val = K3;
         end
      endcase
   end

   assign t_val = rol(work_ff[0], 5) + f_val + work_ff[4] + k_val + w_cur;

   always_comb begin
      blk_in    = blk_ff;
      bitlen_in = bitlen_ff;
      pos_in    = pos_ff;
      for (int i = 0; i < 5; i++) begin
         work_in[i]  = work_ff[i];
         chain_in[i] = chain_ff[i];
      end
      if (cmd.put_byte) begin
         blk_in = {blk_ff[503:0], byte_val};
         pos_in = pos_ff + 6'd1;
      end
      if (cmd.count_bits) begin
         bitlen_in = bitlen_ff + 64'd8;
      end
      if (cmd.load_work) begin
         for (int i = 0; i < 5; i++) begin
            work_in[i] = chain_ff[i];
         end
      end
      if (cmd.round_en) begin
         blk_in     = {blk_ff[479:0], w_new};
         work_in[0] = t_val;
         work_in[1] = work_ff[0];
         work_in[2] = rol(work_ff[1], 30);
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
      end
      if (cmd.add_chain) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.reload) begin
         chain_in[0] = IV0;
         chain_in[1] = IV1;
         chain_in[2] = IV2;
         chain_in[3] = IV3;
         chain_in[4] = IV4;
         bitlen_in   = '0;
         pos_in      = '0;
      end
   end

   always_comb begin
      case (cmd.out_sel)
         3'd0:    digest_word = chain_ff[0];
         3'd1:    digest_word = chain_ff[1];
         3'd2:    digest_word = chain_ff[2];
         3'd3:    digest_word = chain_ff[3];
         3'd4:    digest_word = chain_ff[4];
         default: digest_word = chain_ff[4];
      endcase
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      for (int i = 0; i < 5; i++) begin
         work_ff[i] <= work_in[i];
      end
      if (reset) begin
         chain_ff[0] <= IV0;
         chain_ff[1] <= IV1;
         chain_ff[2] <= IV2;
         chain_ff[3] <= IV3;
         chain_ff[4] <= IV4;
         bitlen_ff   <= '0;
         pos_ff      <= '0;
      end else begin
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= chain_in[i];
         end
         bitlen_ff <= bitlen_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

// File: rtl/core/sha1_message_hasher.sv
// ----------------------------------------------------------------------------
// sha1_message_hasher
// byte-serial sha-1: packs bytes, compresses 64-byte blocks, pads, emits digest
// ----------------------------------------------------------------------------
// a byte item is taken while the sequencer is idle; the item holding the 64th
// byte of a block then runs the 80 rounds on the shared round unit and the chaining add
// a last item then shifts in the padding bytes and compresses each padded block,
// up to two padded blocks, then five digest items at one per cycle while rsp_ready is high
// no item is taken while the digest is read out
// synchronous reset loads the initial chaining values and clears all counters
module sha1_message_hasher import sha1_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   cmd_type    cmd;
   status_type status;

   sha1_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_valid (req_byte_valid),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word),
      .cmd            (cmd),
      .status         (status)
   );

   sha1_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_data_byte),
      .cmd         (cmd),
      .status      (status),
      .digest_word (rsp_digest_word)
   );

endmodule

// File: rtl/core/sha1_checker.sv
// ----------------------------------------------------------------------------
// sha1_checker
// port-level checks on digest readout, bound to the top level
// ----------------------------------------------------------------------------
module sha1_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
         && $stable(rsp_word_index))
      else $error("stalled digest item changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd4)))
      else $error("last_word does not match word index");

   // readout words follow one another without a gap
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
         rsp_valid && (rsp_word_index == 3'($past(rsp_word_index) + 3'd1)))
      else $error("digest words out of order");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken during digest readout");

endmodule

bind sha1_message_hasher sha1_checker u_sha1_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_last_word   (rsp_last_word)
);

// File: tb/sha1_tb_pkg.sv
// ----------------------------------------------------------------------------
// sha1_tb_pkg
// digest scoreboard: tracks the hash of each message as its bytes are accepted
// and holds the digest words the hasher must return, in order
// ----------------------------------------------------------------------------
package sha1_tb_pkg;
   import sha1_pkg::*;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last_word;
   } digest_word_type;

   class sha1_digest_scoreboard;
      logic [31:0]     chain[5];
      logic [31:0]     block[16];
      logic [63:0]     bit_count;
      logic [5:0]      byte_pos;
      digest_word_type pending_digest_words[$];
      int              errors;

      function new();
         errors = 0;
         foreach (block[k]) block[k] = '0;
         restart_message();
      endfunction

      function void restart_message();
         chain[0]  = IV0;
         chain[1]  = IV1;
         chain[2]  = IV2;
         chain[3]  = IV3;
         chain[4]  = IV4;
         bit_count = '0;
         byte_pos  = '0;
      endfunction

      function logic [31:0] rotl(input logic [31:0] v, input int s);
         return (v << s) | (v >> (32 - s));
      endfunction

      function void compress_block();
         logic [31:0] a, b, c, d, e, f, kc, w, t;
         int          r;
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (r = 0; r < 80; r++) begin
            if (r >= 16) begin
               block[r % 16] = rotl(block[(r + 13) % 16] ^ block[(r + 8) % 16]
                                    ^ block[(r + 2) % 16] ^ block[r % 16], 1);
            end
            w = block[r % 16];
            if (r < 20) begin
               f  = (b & c) | (~b & d);
               kc = K0;
            end else if (r < 40) begin
               f  = b ^ c ^ d;
               kc = K1;
            end else if (r < 60) begin
               f  = (b & c) | (b & d) | (c & d);
               kc = K2;
            end else begin
               f  = b ^ c ^ d;
               kc = K3;
            end
            t = rotl(a, 5) + f + e + kc + w;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      function void pack_byte(input logic [7:0] v);
         block[byte_pos[5:2]][(3 - int'(byte_pos[1:0])) * 8 +: 8] = v;
         byte_pos = byte_pos + 6'd1;
         if (byte_pos == 6'd0) compress_block();
      endfunction

      function void absorb_item(input logic [7:0] data_byte, input logic byte_valid,
                                input logic last);
         logic [63:0]     len;
         digest_word_type dw;
         int              k;
         if (byte_valid) begin
            bit_count += 64'd8;
            pack_byte(data_byte);
         end
         if (last) begin
            len = bit_count;
            pack_byte(PAD_BYTE);
            while (byte_pos != LENGTH_POS) pack_byte(8'h00);
            for (k = 0; k < 8; k++) pack_byte(len[63 - 8 * k -: 8]);
            for (k = 0; k < 5; k++) begin
               dw.word      = chain[k];
               dw.index     = 3'(k);
               dw.last_word = (3'(k) == LAST_WORD);
               pending_digest_words.push_back(dw);
            end
            restart_message();
         end
      endfunction

      function void check_digest_word(input logic [31:0] word, input logic [2:0] index,
                                      input logic last_word);
         digest_word_type dw;
         if (pending_digest_words.size() == 0) begin
            $error("unexpected digest word %h (index %0d)", word, index);
            errors++;
            return;
         end
         dw = pending_digest_words.pop_front();
         if (word !== dw.word) begin
            $error("digest_word: expected %h, got %h", dw.word, word);
            errors++;
         end
         if (index !== dw.index) begin
            $error("word_index: expected %0d, got %0d", dw.index, index);
            errors++;
         end
         if (last_word !== dw.last_word) begin
            $error("last_word: expected %0b, got %0b", dw.last_word, last_word);
            errors++;
         end
      endfunction

      function int pending();
         return pending_digest_words.size();
      endfunction
   endclass

endpackage

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// feeds messages byte by byte into the hasher under random stalls on both
// sides and checks every digest word against a software sha-1 tracker
// ----------------------------------------------------------------------------
module tb_top;
   import sha1_pkg::*;
   import sha1_tb_pkg::*;

   localparam int ITEM_TARGET = 410;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_byte_valid;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha1_digest_scoreboard sb;
   int items_sent;
   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles;

   sha1_message_hasher dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_byte_valid  (req_byte_valid),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.absorb_item(req_data_byte, req_byte_valid, req_last);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_digest_word(rsp_digest_word, rsp_word_index, rsp_last_word);
   end

   // stall watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic update_idling();
      if (items_sent < ITEM_TARGET / 3) begin
         send_idle_pct = 7;
         recv_idle_pct = 62;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
         send_idle_pct = 62;
         recv_idle_pct = 7;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   task automatic send_item(input logic [7:0] data_byte, input logic byte_valid,
                            input logic last);
      update_idling();
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data_byte;
      req_byte_valid <= byte_valid;
      req_last       <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // random content; the end is either on the final byte or a separate item
   task automatic send_message(input int n);
      logic end_on_byte;
      int   k;
      end_on_byte = (n > 0) && ($urandom_range(0, 1) == 1);
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 8) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (k == n - 1));
      end
      if (!end_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      int pick;
      int n;
      sb             = new();
      items_sent     = 0;
      send_idle_pct  = 7;
      recv_idle_pct  = 62;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      req_byte_valid = 1'b0;
      req_last       = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty item, then an empty message
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      // single zero byte ending the message
      send_item(8'h00, 1'b1, 1'b1);
      // empty item inside a message, end without a byte
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h55, 1'b0, 1'b1);
      // "abc"
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);

      // block boundaries: padding fits, padding overflows, exact block
      send_message(55);
      send_message(56);
      send_message(64);
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) n = $urandom_range(0, 8);
         else if (pick < 9) n = $urandom_range(52, 66);
         else n = $urandom_range(110, 130);
         if (n > ITEM_TARGET - items_sent) n = ITEM_TARGET - items_sent;
         send_message(n);
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
